// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the steering core.
// Every module that asserts has a clock named aclk and an active-low reset aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define GGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define GGS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ggs_pkg.sv =====
package ggs_pkg;

    // Number of CORDIC rotation cells; the arctangent table covers up to 24.
    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    localparam int POS_W   = 16;
    localparam int OFS_W   = POS_W + 1;
    localparam int HD_W    = 15;
    localparam int XY_W    = 32;
    localparam int Z_W     = 24;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;
    localparam int SPD_W   = 15;
    localparam int TURN_W  = 15;
    localparam int DIST_W  = 17;
    localparam int ERR_W   = 18;
    localparam int AERR_W  = 17;
    localparam int XU_W    = 31;
    localparam int INV_W   = 30;
    localparam int PROD_W  = XU_W + INV_W;
    localparam int DSH     = 42;
    localparam int SPROD_W = GAIN_W + DIST_W;
    localparam int SSH     = 12;
    localparam int COORD_SH = 12;
    localparam int ZSH     = 8;

    localparam logic signed [Z_W-1:0] ANGLE_PI = Z_W'(3294199);
    localparam logic [INV_W-1:0]      INV_GAIN = INV_W'(652032874);
    localparam logic [PROD_W-1:0]     DIST_RND = PROD_W'(1) << (DSH - 1);
    localparam logic [SPROD_W:0]      SPD_RND  = (SPROD_W + 1)'(1) << (SSH - 1);
    localparam logic signed [Z_W:0]   Z_RND    = (Z_W + 1)'(1) << (ZSH - 1);

    // round(atan(2^-i) * 2^20)
    localparam logic [19:0] ATAN_TAB [24] = '{
        20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
        20'd16383,  20'd8192,   20'd4096,   20'd2048,   20'd1024,  20'd512,
        20'd256,    20'd128,    20'd64,     20'd32,     20'd16,    20'd8,
        20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
    };

    typedef enum logic [2:0] {
        REG_TARGET_X      = 3'd0,
        REG_TARGET_Y      = 3'd1,
        REG_SPEED_GAIN    = 3'd2,
        REG_MAX_SPEED     = 3'd3,
        REG_STOP_DISTANCE = 3'd4,
        REG_AIM_TOLERANCE = 3'd5
    } ggs_reg_t;

    // Vector carried down the rotation chain, with the heading riding along.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [HD_W-1:0] hd;
    } ggs_vec_t;

    // Configuration the output stages need.
    typedef struct packed {
        logic [GAIN_W-1:0] speed_gain;
        logic [LIM_W-1:0]  max_speed;
        logic [LIM_W-1:0]  stop_distance;
        logic [LIM_W-1:0]  aim_tolerance;
    } ggs_limits_t;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [IDX_W-1:0] idx);
        return $signed({{(Z_W - 20){1'b0}}, ATAN_TAB[idx]});
    endfunction

endpackage

// ===== rtl/core/ggs_cordic_cell.sv =====
`include "assert_macros.svh"

module ggs_cordic_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [ggs_pkg::IDX_W-1:0] stage_idx,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ggs_pkg::ggs_vec_t        in_vec,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ggs_pkg::ggs_vec_t        out_vec
);
    import ggs_pkg::*;

    logic                   valid_reg;
    ggs_vec_t               vec_reg;
    ggs_vec_t               vec_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  ang;

    // One vectoring rotation: drive y toward zero and track the angle.
    always_comb begin
        xs       = in_vec.x >>> stage_idx;
        ys       = in_vec.y >>> stage_idx;
        ang      = atan_step(stage_idx);
        vec_next = in_vec;
        if (!in_vec.y[XY_W-1]) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ang;
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ang;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

    `GGS_ASSERT_NEXT(a_cell_hold, valid_reg && !out_ready, valid_reg && $stable(vec_reg),
        "cordic cell lost or changed a stalled item")

endmodule

// ===== rtl/core/ggs_post.sv =====
`include "assert_macros.svh"

module ggs_post (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ggs_pkg::ggs_limits_t        limits,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ggs_pkg::ggs_vec_t           in_vec,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ggs_pkg::SPD_W-1:0]   linear_speed,
    output logic [ggs_pkg::TURN_W-1:0]  turn_rate
);
    import ggs_pkg::*;

    // Stage 1: gain correction product and bearing error magnitude.
    logic                v1_reg;
    logic [PROD_W-1:0]   prod1_reg;
    logic [AERR_W-1:0]   aerr1_reg;
    // Stage 2: rounded distance and the aim test.
    logic                v2_reg;
    logic [DIST_W-1:0]   dist2_reg;
    logic [AERR_W-1:0]   aerr2_reg;
    logic                turn2_reg;
    // Stage 3: speed product and the stop test.
    logic                v3_reg;
    logic [SPROD_W-1:0]  sprod3_reg;
    logic [AERR_W-1:0]   aerr3_reg;
    logic                turn3_reg;
    logic                stop3_reg;
    // Stage 4: output register.
    logic                v4_reg;
    logic [SPD_W-1:0]    speed4_reg;
    logic [TURN_W-1:0]   turn4_reg;

    logic                rdy1, rdy2, rdy3, rdy4;
    logic [XU_W-1:0]     x_u;
    logic signed [Z_W:0] zsum;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]    aerr_full;
    logic [PROD_W-1:0]   dsum;
    logic [SPROD_W:0]    ssum;
    logic [SPROD_W-SSH:0] speed_raw;
    logic [SPD_W-1:0]    speed_sat;
    logic [SPD_W-1:0]    speed4_next;
    logic [TURN_W-1:0]   turn4_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        x_u       = in_vec.x[XU_W-1:0];
        zsum      = {in_vec.z[Z_W-1], in_vec.z} + Z_RND;
        err       = ERR_W'($signed(zsum[Z_W:ZSH])) - ERR_W'(in_vec.hd);
        aerr_full = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    end

    always_comb begin
        dsum      = prod1_reg + DIST_RND;
        ssum      = {1'b0, sprod3_reg} + SPD_RND;
        speed_raw = ssum[SPROD_W:SSH];
        if (speed_raw > (SPROD_W - SSH + 1)'(limits.max_speed)) begin
            speed_sat = limits.max_speed;
        end else begin
            speed_sat = speed_raw[SPD_W-1:0];
        end
        speed4_next = '0;
        turn4_next  = '0;
        if (!stop3_reg) begin
            if (turn3_reg) begin
                turn4_next = aerr3_reg[TURN_W-1:0];
            end else begin
                speed4_next = speed_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod1_reg <= PROD_W'(x_u) * PROD_W'(INV_GAIN);
            aerr1_reg <= aerr_full[AERR_W-1:0];
        end
        if (rdy2 && v1_reg) begin
            dist2_reg <= dsum[DSH +: DIST_W];
            aerr2_reg <= aerr1_reg;
            turn2_reg <= aerr1_reg > AERR_W'(limits.aim_tolerance);
        end
        if (rdy3 && v2_reg) begin
            sprod3_reg <= SPROD_W'(limits.speed_gain) * SPROD_W'(dist2_reg);
            aerr3_reg  <= aerr2_reg;
            turn3_reg  <= turn2_reg;
            stop3_reg  <= dist2_reg <= DIST_W'(limits.stop_distance);
        end
        if (rdy4 && v3_reg) begin
            speed4_reg <= speed4_next;
            turn4_reg  <= turn4_next;
        end
    end

    assign out_valid    = v4_reg;
    assign linear_speed = speed4_reg;
    assign turn_rate    = turn4_reg;

    `GGS_ASSERT(a_post_exclusive, !v4_reg || speed4_reg == '0 || turn4_reg == '0,
        "speed and turn commands are both nonzero")
    `GGS_ASSERT_NEXT(a_post_no_extra, v4_reg && out_ready && !v3_reg, !v4_reg,
        "output stage repeated an item")

endmodule

// ===== rtl/core/go_to_goal_steering_core.sv =====
// Go-to-goal steering core. Each input item is a pose (x, y in signed Q6.10, heading
// in signed Q3.12 radians); each produces exactly one result item with a forward
// speed (Q5.10) and a turn command (Q3.12 rad/s), at most one of them nonzero. The
// offset to the configured target is fed through a chain of CORDIC vectoring cells,
// one rotation per cell, which yields the distance and the bearing. When the
// distance is at or below stop_distance both commands are zero; when the absolute
// bearing error exceeds aim_tolerance only the turn command is set; otherwise the
// speed is speed_gain times distance, limited to max_speed. The pipeline accepts one
// item per cycle while the output is not stalled. The stages are the offset register,
// one register per CORDIC cell, the gain correction multiply, the rounding, the
// speed multiply and the output register. Every stage holds its item
// only while the next one is full, so empty slots are squeezed out under output
// backpressure. Configuration registers are written through a simple write port and
// must only change while no item is in flight.
`include "assert_macros.svh"

module go_to_goal_steering_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Pose input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [15:0], pos_y [31:16], heading [46:32]
    // Command output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // linear_speed [14:0], turn_rate [29:15]
);
    import ggs_pkg::*;

    // Configuration registers.
    logic [POS_W-1:0]  target_x_reg;
    logic [POS_W-1:0]  target_y_reg;
    logic [GAIN_W-1:0] speed_gain_reg;
    logic [LIM_W-1:0]  max_speed_reg;
    logic [LIM_W-1:0]  stop_distance_reg;
    logic [LIM_W-1:0]  aim_tolerance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg      <= POS_W'(1024);
            target_y_reg      <= POS_W'(1024);
            speed_gain_reg    <= GAIN_W'(4096);
            max_speed_reg     <= LIM_W'(3072);
            stop_distance_reg <= LIM_W'(102);
            aim_tolerance_reg <= LIM_W'(819);
        end else if (cfg_we) begin
            case (ggs_reg_t'(cfg_addr))
                REG_TARGET_X:      target_x_reg      <= cfg_wdata;
                REG_TARGET_Y:      target_y_reg      <= cfg_wdata;
                REG_SPEED_GAIN:    speed_gain_reg    <= cfg_wdata;
                REG_MAX_SPEED:     max_speed_reg     <= cfg_wdata[LIM_W-1:0];
                REG_STOP_DISTANCE: stop_distance_reg <= cfg_wdata[LIM_W-1:0];
                REG_AIM_TOLERANCE: aim_tolerance_reg <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the pose.
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [HD_W-1:0]  heading;

    assign pos_x   = s_tdata[15:0];
    assign pos_y   = s_tdata[31:16];
    assign heading = s_tdata[46:32];

    // Offset stage. A vector pointing into the left half plane is turned by pi so
    // that the rotation chain starts in the right half plane.
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    logic signed [XY_W-1:0]  dx_ext;
    logic signed [XY_W-1:0]  dy_ext;
    ggs_vec_t                pre_next;
    ggs_vec_t                pre_reg;
    logic                    pre_valid_reg;
    logic                    pre_ready;

    always_comb begin
        dx     = {target_x_reg[POS_W-1], target_x_reg} - {pos_x[POS_W-1], pos_x};
        dy     = {target_y_reg[POS_W-1], target_y_reg} - {pos_y[POS_W-1], pos_y};
        dx_ext = XY_W'(dx);
        dy_ext = XY_W'(dy);
        pre_next.hd = $signed(heading);
        if (dx[OFS_W-1]) begin
            pre_next.x = (-dx_ext) <<< COORD_SH;
            pre_next.y = (-dy_ext) <<< COORD_SH;
            pre_next.z = dy[OFS_W-1] ? -ANGLE_PI : ANGLE_PI;
        end else begin
            pre_next.x = dx_ext <<< COORD_SH;
            pre_next.y = dy_ext <<< COORD_SH;
            pre_next.z = '0;
        end
    end

    // Rotation chain: link k feeds cell k, link CORDIC_STAGES feeds the output stages.
    logic     link_valid [CORDIC_STAGES+1];
    logic     link_ready [CORDIC_STAGES+1];
    ggs_vec_t link_vec   [CORDIC_STAGES+1];

    assign pre_ready  = !pre_valid_reg || link_ready[0];
    assign s_tready   = pre_ready;
    assign link_valid[0] = pre_valid_reg;
    assign link_vec[0]   = pre_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (pre_ready) begin
            pre_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pre_ready && s_tvalid) begin
            pre_reg <= pre_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        ggs_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (IDX_W'(k)),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_vec    (link_vec[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_vec   (link_vec[k+1])
        );
    end

    // Distance scaling, thresholds and command selection.
    ggs_limits_t       limits;
    logic [SPD_W-1:0]  linear_speed;
    logic [TURN_W-1:0] turn_rate;

    assign limits.speed_gain    = speed_gain_reg;
    assign limits.max_speed     = max_speed_reg;
    assign limits.stop_distance = stop_distance_reg;
    assign limits.aim_tolerance = aim_tolerance_reg;

    ggs_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .limits       (limits),
        .in_valid     (link_valid[CORDIC_STAGES]),
        .in_ready     (link_ready[CORDIC_STAGES]),
        .in_vec       (link_vec[CORDIC_STAGES]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate)
    );

    assign m_tdata = {2'b00, turn_rate, linear_speed};

    // The input can only stall when every stage is full, which means a result
    // must be waiting at the output.
    `GGS_ASSERT(a_top_stall_source, s_tready || (m_tvalid && !m_tready),
        "input stalled with no result waiting at the output")

endmodule

// ===== dv/ggs_command_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams and the register port of the steering core. Every accepted
// pose item gets its expected command computed from a private copy of the registers;
// every accepted command item is compared against the oldest expectation.
module ggs_command_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [15:0], pos_y [31:16], heading [46:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // linear_speed [14:0], turn_rate [29:15]
    output int          mismatches,
    output int          poses_in,
    output int          commands_out,
    output int          stops_seen,
    output int          turns_seen,
    output int          drives_seen
);
    import ggs_pkg::*;

    localparam longint          PI_Q20        = 64'sd3294199;
    localparam longint unsigned CORDIC_INV_Q30 = 64'd652032874;

    logic signed [POS_W-1:0] goal_x, goal_y;
    logic [GAIN_W-1:0]       gain;
    logic [LIM_W-1:0]        speed_cap, stop_radius, turn_band;

    logic [31:0] due_commands [$];

    // Elementary rotation angles, atan(2^-i) in Q20.
    function automatic longint arc_q20(input int i);
        case (i)
            0: return 823550;   1: return 486170;  2: return 256879;  3: return 130396;
            4: return 65451;    5: return 32757;   6: return 16383;   7: return 8192;
            8: return 4096;     9: return 2048;    10: return 1024;   11: return 512;
            12: return 256;     13: return 128;    14: return 64;     15: return 32;
            16: return 16;      17: return 8;      18: return 4;      19: return 2;
            20: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] steer_command(input logic [47:0] pose);
        longint          px, py, hd, dx, dy, xv, yv, zv, xs, ys, err;
        longint unsigned distance, speed, turn;
        int              i;
        px = $signed(pose[15:0]);
        py = $signed(pose[31:16]);
        hd = $signed(pose[46:32]);
        dx = goal_x - px;
        dy = goal_y - py;
        // Fold the left half plane onto the right one and start the angle at +-pi.
        if (dx < 0) begin
            xv = -dx;
            yv = -dy;
            zv = (dy >= 0) ? PI_Q20 : -PI_Q20;
        end else begin
            xv = dx;
            yv = dy;
            zv = 0;
        end
        xv = xv * 4096;
        yv = yv * 4096;
        for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + arc_q20(i);
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - arc_q20(i);
            end
        end
        distance = ($unsigned(xv) * CORDIC_INV_Q30 + (64'd1 << 41)) >> 42;
        err  = ((zv + 128) >>> 8) - hd;
        if (err < 0) err = -err;
        speed = 0;
        turn  = 0;
        if (distance > stop_radius) begin
            if (err > turn_band) begin
                turn = err;
            end else begin
                speed = (gain * distance + 2048) >> 12;
                if (speed > speed_cap) speed = speed_cap;
            end
        end
        return {2'b00, turn[14:0], speed[14:0]};
    endfunction

    always @(posedge aclk) begin : watch
        logic [31:0] want;
        if (!aresetn) begin
            goal_x      <= 16'sd1024;
            goal_y      <= 16'sd1024;
            gain        <= 16'd4096;
            speed_cap   <= 15'd3072;
            stop_radius <= 15'd102;
            turn_band   <= 15'd819;
        end else begin
            if (s_tvalid && s_tready) begin
                due_commands.push_back(steer_command(s_tdata));
                poses_in <= poses_in + 1;
            end
            if (m_tvalid && m_tready) begin
                if (due_commands.size() == 0) begin
                    $display("%0t: command %h arrived with no pose waiting", $time, m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = due_commands.pop_front();
                    commands_out <= commands_out + 1;
                    if (m_tdata !== want) begin
                        $display({"%0t: expected speed %0d turn %0d (%h), ",
                                  "got speed %0d turn %0d (%h)"},
                                 $time, want[14:0], want[29:15], want,
                                 m_tdata[14:0], m_tdata[29:15], m_tdata);
                        mismatches <= mismatches + 1;
                    end
                    if (want[29:15] != 0) turns_seen <= turns_seen + 1;
                    else if (want[14:0] != 0) drives_seen <= drives_seen + 1;
                    else stops_seen <= stops_seen + 1;
                end
            end
            // Writes only happen with the pipeline empty; indexes past the list are dropped.
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TARGET_X:      goal_x      <= cfg_wdata;
                    REG_TARGET_Y:      goal_y      <= cfg_wdata;
                    REG_SPEED_GAIN:    gain        <= cfg_wdata;
                    REG_MAX_SPEED:     speed_cap   <= cfg_wdata[14:0];
                    REG_STOP_DISTANCE: stop_radius <= cfg_wdata[14:0];
                    REG_AIM_TOLERANCE: turn_band   <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the go-to-goal steering core. The checker beside the
// core does all prediction and comparison; this module only makes traffic: a short
// directed set of poses under the reset registers and two extreme register settings,
// then several phases of shaped random poses, each under a fresh register setting.
module tb_top;
    import ggs_pkg::*;

    localparam int LATENCY      = CORDIC_STAGES + 5;
    localparam int HOLD_CYCLES  = 200;
    localparam int BURST_ITEMS  = 64;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Register indexes past the end of the map; writes to them must change nothing.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // pos_x [15:0], pos_y [31:16], heading [46:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // linear_speed [14:0], turn_rate [29:15]

    int mismatches, poses_in, commands_out, stops_seen, turns_seen, drives_seen;
    int cycles   = 0;
    int settings = 1;

    // Traffic shaping flags for the sender and the receiver.
    bit calm     = 1'b0;   // neither side idles
    bit eager    = 1'b0;   // the sender offers items back to back
    bit hold_off = 1'b0;   // the receiver stalls once for HOLD_CYCLES

    // Copy of the target and thresholds: the values written to the core, kept to aim the random poses.
    int goal_x = 1024;
    int goal_y = 1024;
    int stop_r = 102;
    int band   = 819;

    go_to_goal_steering_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ggs_command_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .poses_in     (poses_in),
        .commands_out (commands_out),
        .stops_seen   (stops_seen),
        .turns_seen   (turns_seen),
        .drives_seen  (drives_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Hard stop in case the core wedges and a handshake never completes.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d commands outstanding.",
                     cycles, poses_in - commands_out);
            $display("** go_to_goal_steering_core: FAILED **");
            $finish;
        end
    end

    // Length of an idle stretch: mostly none, often short, rarely long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int spread(input int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Picks a register value: the two ends of its range now and then, otherwise a
    // value between lo and typ_hi, a bound that keeps the behavior interesting.
    function automatic int pick_reg(input int lo, input int hi, input int typ_hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return lo + int'($urandom_range(0, typ_hi - lo));
    endfunction

    // The receiver. Normally it stalls at random; on request it holds off for a
    // long stretch so the pipeline fills and the core has to drop s_tready.
    initial begin : receiver
        int len;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
                m_tready <= 1'b1;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
            end else begin
                len = idle_len() + 1;
                m_tready <= 1'b0;
                repeat (len - 1) @(negedge aclk);
            end
        end
    end

    // One register write. Called at a falling edge, returns at a falling edge with
    // the write enable low again, so back-to-back calls never collide.
    task automatic reg_write(input logic [2:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 16'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Offers one pose item and returns at the falling edge after it was taken.
    // s_tvalid stays high on return so that the next item can follow directly.
    task automatic push_pose(input int px, input int py, input int hd);
        int gap;
        gap = (calm || eager) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, 15'(hd), 16'(py), 16'(px)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering items and waits until every pose has its command, plus the
    // pipeline latency so the core is surely idle before registers change.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (poses_in != commands_out) @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
    endtask

    // Draws a fresh register setting and writes every register.
    task automatic new_setting();
        goal_x = pick_reg(-32768, 32767, 32767);
        goal_y = pick_reg(-32768, 32767, 32767);
        stop_r = pick_reg(0, 32767, 3000);
        band   = pick_reg(0, 25736, 25736);
        reg_write(REG_TARGET_X, goal_x);
        reg_write(REG_TARGET_Y, goal_y);
        reg_write(REG_SPEED_GAIN, pick_reg(0, 65535, 20000));
        reg_write(REG_MAX_SPEED, pick_reg(0, 32767, 32767));
        reg_write(REG_STOP_DISTANCE, stop_r);
        reg_write(REG_AIM_TOLERANCE, band);
        settings++;
    endtask

    // One random pose. Most are placed around the target at a random scale, and
    // many of those are pointed roughly at it so the drive branch and the aim
    // tolerance edge get exercised; the rest are raw bit patterns and far poses.
    task automatic random_pose();
        int  mode, px, py, hd, a;
        real brg;
        mode = $urandom_range(0, 99);
        if (mode < 20) begin
            // Close to the stop radius.
            px = clamp(goal_x + spread(stop_r + 40), -32768, 32767);
            py = clamp(goal_y + spread(stop_r + 40), -32768, 32767);
            hd = spread(12868);
        end else if (mode < 60) begin
            // Somewhere around the target, heading near the bearing to it.
            a  = 1 << $urandom_range(0, 15);
            px = clamp(goal_x + spread(a), -32768, 32767);
            py = clamp(goal_y + spread(a), -32768, 32767);
            brg = $atan2(goal_y - py, goal_x - px);
            a  = (band < 2000) ? band : 2000;
            hd = clamp($rtoi(brg * 4096.0) + spread(a + 30), -16384, 16383);
        end else if (mode < 85) begin
            // Any bit pattern at all, headings outside plus or minus pi included.
            px = $urandom_range(0, 65535);
            py = $urandom_range(0, 65535);
            hd = $urandom_range(0, 32767);
        end else begin
            px = int'($urandom_range(0, 65535)) - 32768;
            py = int'($urandom_range(0, 65535)) - 32768;
            hd = spread(12868);
        end
        push_pose(px, py, hd);
    endtask

    initial begin : stimulus
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset registers: target (1.0, 1.0), stop radius 102, aim tolerance 819.
        push_pose(1024, 1024, 0);          // exactly at the target
        push_pose(922, 1024, 0);           // distance on the stop radius
        push_pose(921, 1024, 0);
        push_pose(923, 1024, 0);
        push_pose(0, 1024, -819);          // bearing error on the aim tolerance
        push_pose(0, 1024, -818);
        push_pose(0, 1024, -820);
        push_pose(0, 1024, 819);
        push_pose(2048, 1024, 12868);      // target behind, bearing near +pi
        push_pose(2048, 2048, -12868);     // target behind and below, near -pi
        push_pose(-32768, -32768, 3217);   // far and aligned: speed saturates
        push_pose(-32768, -32768, 0);      // far and misaligned: turn
        push_pose(32767, 32767, -16384);   // heading patterns beyond plus or minus pi
        push_pose(32767, -32768, 16383);
        drain();

        // Extreme setting: corner target, full gain and limits, zero stop radius.
        goal_x = -32768;
        goal_y = 32767;
        stop_r = 0;
        band   = 25736;
        reg_write(REG_TARGET_X, goal_x);
        reg_write(REG_TARGET_Y, goal_y);
        reg_write(REG_SPEED_GAIN, 65535);
        reg_write(REG_MAX_SPEED, 32767);
        reg_write(REG_STOP_DISTANCE, stop_r);
        reg_write(REG_AIM_TOLERANCE, band);
        reg_write(REG_SPARE_LO, 16'hFFFF);
        reg_write(REG_SPARE_HI, 16'h0000);
        settings++;
        push_pose(-32768, 32767, 0);       // at the target with a zero stop radius
        push_pose(-32767, 32767, 0);       // one step off the target
        push_pose(32767, -32768, 0);       // longest offset, driving
        push_pose(32767, -32768, -16384);  // longest offset, error past the tolerance
        push_pose(32767, 32767, 16383);
        drain();

        // Opposite extreme: zero gain and limits, widest stop radius, zero tolerance.
        goal_x = 32767;
        goal_y = -32768;
        stop_r = 32767;
        band   = 0;
        reg_write(REG_TARGET_X, goal_x);
        reg_write(REG_TARGET_Y, goal_y);
        reg_write(REG_SPEED_GAIN, 0);
        reg_write(REG_MAX_SPEED, 0);
        reg_write(REG_STOP_DISTANCE, stop_r);
        reg_write(REG_AIM_TOLERANCE, band);
        settings++;
        push_pose(0, -32768, 0);           // distance near the widest stop radius
        push_pose(-1, -32768, 0);
        push_pose(1, -32768, 0);
        push_pose(-32768, 32767, 5000);
        push_pose(-32768, -32768, 0);      // zero error drives at zero gain
        drain();

        // Random phases. Phase 1 opens with a back-to-back burst against a long
        // receiver hold-off, phase 3 runs with no idling at all, and phase 4 pauses
        // halfway until every command is back.
        for (int ph = 0; ph < PHASES; ph++) begin
            new_setting();
            calm = (ph == 3);
            if (ph == 1) hold_off = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                eager = (ph == 1 && i < BURST_ITEMS);
                if (ph == 4 && i == PHASE_ITEMS / 2) drain();
                random_pose();
            end
            drain();
        end
        calm = 1'b0;

        $display("Sent %0d poses across %0d register settings, with a long output stall.",
                 poses_in, settings);
        $display("Commands checked: %0d stop, %0d turn, %0d drive; %0d mismatches.",
                 stops_seen, turns_seen, drives_seen, mismatches);
        if (mismatches == 0 && poses_in == commands_out) begin
            $display("** go_to_goal_steering_core: PASSED **");
        end else begin
            $display("** go_to_goal_steering_core: FAILED **");
        end
        $finish;
    end

endmodule
